### rtl/core/ibc_pkg.sv
// Package for the indirect block counter: map geometry, term codes and per-term tables.
// Has no dependencies. Every file under rtl/core imports it.
`default_nettype none

package ibc_pkg;

   // Index geometry. The entries per index block must be a power of two.
   localparam int ENTRIES_LOG2 = 9;
   localparam int DIRECT_SLOTS = 12;

   localparam int ADDR_W   = 32;
   localparam int OFF_W    = 3 * ENTRIES_LOG2 + 1;
   localparam int SHIFT_W  = $clog2(3 * ENTRIES_LOG2 + 1);
   localparam int COUNT_W  = 19;

   localparam longint unsigned SIZE1 = 64'd1 << ENTRIES_LOG2;
   localparam longint unsigned SIZE2 = 64'd1 << (2 * ENTRIES_LOG2);
   localparam longint unsigned SIZE3 = 64'd1 << (3 * ENTRIES_LOG2);

   localparam longint unsigned BASE1 = longint'(DIRECT_SLOTS);
   localparam longint unsigned BASE2 = BASE1 + SIZE1;
   localparam longint unsigned BASE3 = BASE2 + SIZE2;

   localparam logic [ADDR_W-1:0] SINGLE_BASE = ADDR_W'(BASE1);
   localparam logic [ADDR_W-1:0] DOUBLE_BASE = ADDR_W'(BASE2);
   localparam logic [ADDR_W-1:0] TRIPLE_BASE = ADDR_W'(BASE3);
   localparam logic [ADDR_W-1:0] SINGLE_TOP  = ADDR_W'(BASE1 + SIZE1 - 64'd1);
   localparam logic [ADDR_W-1:0] DOUBLE_TOP  = ADDR_W'(BASE2 + SIZE2 - 64'd1);
   localparam logic [ADDR_W-1:0] TRIPLE_TOP  = ADDR_W'(BASE3 + SIZE3 - 64'd1);

   localparam logic [SHIFT_W-1:0] SHIFT_L1 = SHIFT_W'(ENTRIES_LOG2);
   localparam logic [SHIFT_W-1:0] SHIFT_L2 = SHIFT_W'(2 * ENTRIES_LOG2);
   localparam logic [SHIFT_W-1:0] SHIFT_L3 = SHIFT_W'(3 * ENTRIES_LOG2);

   // One term per (region, group size) pair.
   typedef enum logic [2:0] {
      TERM_S1 = 3'd0,
      TERM_D1 = 3'd1,
      TERM_D2 = 3'd2,
      TERM_T1 = 3'd3,
      TERM_T2 = 3'd4,
      TERM_T3 = 3'd5
   } term_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_ISSUE,
      ST_FINISH,
      ST_DELIVER
   } state_type;

   typedef struct packed {
      logic     clear;
      logic     issue;
      term_type term;
   } unit_ctrl_type;

   typedef struct packed {
      logic accept;
      logic load_out;
   } seq_ctrl_type;

   function automatic logic [ADDR_W-1:0] term_base(input term_type t);
      logic [ADDR_W-1:0] r;
      unique case (t)
         TERM_S1:                   r = SINGLE_BASE;
         TERM_D1, TERM_D2:          r = DOUBLE_BASE;
         TERM_T1, TERM_T2, TERM_T3: r = TRIPLE_BASE;
         default:                   r = SINGLE_BASE;
      endcase
      return r;
   endfunction

   function automatic logic [ADDR_W-1:0] term_top(input term_type t);
      logic [ADDR_W-1:0] r;
      unique case (t)
         TERM_S1:                   r = SINGLE_TOP;
         TERM_D1, TERM_D2:          r = DOUBLE_TOP;
         TERM_T1, TERM_T2, TERM_T3: r = TRIPLE_TOP;
         default:                   r = SINGLE_TOP;
      endcase
      return r;
   endfunction

   function automatic logic [SHIFT_W-1:0] term_shift(input term_type t);
      logic [SHIFT_W-1:0] r;
      unique case (t)
         TERM_S1, TERM_D1, TERM_T1: r = SHIFT_L1;
         TERM_D2, TERM_T2:          r = SHIFT_L2;
         TERM_T3:                   r = SHIFT_L3;
         default:                   r = SHIFT_L1;
      endcase
      return r;
   endfunction

endpackage

`default_nettype wire

### rtl/core/ibc_region_unit.sv
// Shared region counting unit: clamps the range to one region, then counts the groups closed.
// Depends on ibc_pkg. Two register stages; the second holds the running total.
`default_nettype none

module ibc_region_unit (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire ibc_pkg::unit_ctrl_type        ctrl,
   input  wire logic [ibc_pkg::ADDR_W-1:0]    lo,
   input  wire logic [ibc_pkg::ADDR_W-1:0]    hi,
   output logic      [ibc_pkg::COUNT_W-1:0]   total
);
   import ibc_pkg::*;

   logic [ADDR_W-1:0]  base;
   logic [ADDR_W-1:0]  top;
   logic [ADDR_W-1:0]  clamp_a;
   logic [ADDR_W-1:0]  clamp_b;

   logic               s1_valid_ff, s1_valid_in;
   logic               s1_nonempty_ff, s1_nonempty_in;
   logic               s1_at_end_ff, s1_at_end_in;
   logic [OFF_W-1:0]   s1_off_a_ff, s1_off_a_in;
   logic [OFF_W-1:0]   s1_off_b1_ff, s1_off_b1_in;
   logic [SHIFT_W-1:0] s1_shift_ff, s1_shift_in;

   logic [OFF_W-1:0]   quot_a;
   logic [OFF_W-1:0]   quot_b;
   logic [OFF_W-1:0]   rem_mask;
   logic               partial;
   logic [OFF_W-1:0]   groups;
   logic [COUNT_W-1:0] acc_ff, acc_in;

   // Stage one: clamp the range to the region and form offsets from its start.
   always_comb begin
      base    = term_base(ctrl.term);
      top     = term_top(ctrl.term);
      clamp_a = (lo > base) ? lo : base;
      clamp_b = (hi < top) ? hi : top;

      s1_valid_in    = ctrl.issue;
      s1_nonempty_in = (clamp_a <= clamp_b);
      s1_at_end_in   = (clamp_b == hi);
      s1_off_a_in    = OFF_W'(clamp_a - base);
      s1_off_b1_in   = OFF_W'(clamp_b - base + ADDR_W'(1));
      s1_shift_in    = term_shift(ctrl.term);
   end

   // Stage two: groups closed, plus one when the range ends part way through a group.
   always_comb begin
      quot_a   = s1_off_a_ff >> s1_shift_ff;
      quot_b   = s1_off_b1_ff >> s1_shift_ff;
      rem_mask = (OFF_W'(1) << s1_shift_ff) - OFF_W'(1);
      partial  = s1_at_end_ff && ((s1_off_b1_ff & rem_mask) != '0);
      groups   = quot_b - quot_a + OFF_W'(partial);

      acc_in = acc_ff;
      priority if (ctrl.clear) begin
         acc_in = '0;
      end else if (s1_valid_ff && s1_nonempty_ff) begin
         acc_in = acc_ff + COUNT_W'(groups);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
         acc_ff      <= '0;
      end else begin
         s1_valid_ff <= s1_valid_in;
         acc_ff      <= acc_in;
      end
   end

   always_ff @(posedge clock) begin
      s1_nonempty_ff <= s1_nonempty_in;
      s1_at_end_ff   <= s1_at_end_in;
      s1_off_a_ff    <= s1_off_a_in;
      s1_off_b1_ff   <= s1_off_b1_in;
      s1_shift_ff    <= s1_shift_in;
   end

   assign total = acc_ff;

endmodule

`default_nettype wire

### rtl/core/ibc_seq.sv
// Sequencer for the indirect block counter: steps the shared unit through the six terms.
// Depends on ibc_pkg.
`default_nettype none

module ibc_seq (
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire logic                   req_valid,
   input  wire logic                   out_free,
   output logic                        busy,
   output ibc_pkg::seq_ctrl_type       seq_ctrl,
   output ibc_pkg::unit_ctrl_type      unit_ctrl
);
   import ibc_pkg::*;

   state_type state_ff, state_in;
   term_type  term_ff, term_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         term_ff  <= TERM_S1;
      end else begin
         state_ff <= state_in;
         term_ff  <= term_in;
      end
   end

   always_comb begin
      state_in  = state_ff;
      term_in   = term_ff;
      busy      = 1'b1;
      seq_ctrl  = '0;
      unit_ctrl = '{clear: 1'b0, issue: 1'b0, term: term_ff};

      unique case (state_ff)
         ST_IDLE: begin
            busy = 1'b0;
            if (req_valid) begin
               seq_ctrl.accept = 1'b1;
               unit_ctrl.clear = 1'b1;
               term_in         = TERM_S1;
               state_in        = ST_ISSUE;
            end
         end
         ST_ISSUE: begin
            unit_ctrl.issue = 1'b1;
            if (term_ff == TERM_T3) begin
               state_in = ST_FINISH;
            end else begin
               term_in = term_type'(term_ff + 3'd1);
            end
         end
         // The last term is still in the second stage of the unit.
         ST_FINISH: begin
            state_in = ST_DELIVER;
         end
         ST_DELIVER: begin
            if (out_free) begin
               seq_ctrl.load_out = 1'b1;
               state_in          = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

endmodule

`default_nettype wire

### rtl/core/indirect_block_count.sv
// Top level of the indirect block counter: input capture, sequencer, shared unit, output register.
// Depends on ibc_pkg, ibc_seq and ibc_region_unit.
//
//   Channel | Handshake                  | Payload
//   --------+----------------------------+--------------------------------------
//   req     | req_valid / req_stall      | req_first_block[31:0], req_last_block[31:0]
//   rsp     | rsp_valid / rsp_stall      | rsp_index_block_count[18:0]
//
// From acceptance until its result is loaded into the output register, a transaction steps
// the shared clamp-and-count unit through the six region/group terms, one issue per term,
// then FINISH drains its second stage and DELIVER loads the result once the output
// register is free. req_stall is high for all of that. A new transaction is taken while
// a result still waits in the output register; delivery of the next one waits for that
// register to empty. Reset is synchronous, active high, clears the sequencer and both valids.
`default_nettype none

module indirect_block_count (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire logic                          req_valid,
   output logic                               req_stall,
   input  wire logic [31:0]                   req_first_block,
   input  wire logic [31:0]                   req_last_block,
   output logic                               rsp_valid,
   input  wire logic                          rsp_stall,
   output logic      [18:0]                   rsp_index_block_count
);
   import ibc_pkg::*;

   logic               busy;
   logic               out_free;
   seq_ctrl_type       seq_ctrl;
   unit_ctrl_type      unit_ctrl;
   logic [ADDR_W-1:0]  lo_ff;
   logic [ADDR_W-1:0]  hi_ff;
   logic [COUNT_W-1:0] total;

   logic               rsp_valid_ff, rsp_valid_in;
   logic [COUNT_W-1:0] rsp_count_ff;

   assign out_free = !rsp_valid_ff || !rsp_stall;

   ibc_seq u_seq (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .out_free  (out_free),
      .busy      (busy),
      .seq_ctrl  (seq_ctrl),
      .unit_ctrl (unit_ctrl)
   );

   ibc_region_unit u_unit (
      .clock (clock),
      .reset (reset),
      .ctrl  (unit_ctrl),
      .lo    (lo_ff),
      .hi    (hi_ff),
      .total (total)
   );

   always_ff @(posedge clock) begin
      if (seq_ctrl.accept) begin
         lo_ff <= req_first_block;
         hi_ff <= req_last_block;
      end
      if (seq_ctrl.load_out) begin
         rsp_count_ff <= total;
      end
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      priority if (seq_ctrl.load_out) begin
         rsp_valid_in = 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign req_stall             = busy;
   assign rsp_valid             = rsp_valid_ff;
   assign rsp_index_block_count = rsp_count_ff;

   // A result waiting on a stalled output is never overwritten.
   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      seq_ctrl.load_out |-> !(rsp_valid_ff && rsp_stall))
      else $error("result loaded over a pending transaction");

   // An accepted transaction keeps the input stalled while it is worked on.
   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      (req_valid && !req_stall) |=> req_stall)
      else $error("input not stalled after acceptance");

   // The shared unit is only issued terms while a transaction is in progress.
   a_issue_when_busy: assert property (@(posedge clock) disable iff (reset)
      unit_ctrl.issue |-> busy && !seq_ctrl.accept)
      else $error("shared unit issued while idle");

endmodule

`default_nettype wire
